// ===== hw/rtl/cdg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Central difference gradient package
// Shared constants, configuration register codes and the position flags that
// travel from the raster control to the difference datapath.
// ----------------------------------------------------------------------------
package cdg_pkg;

  localparam int MAX_COLS_DEFAULT    = 1024;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  // Configuration register widths and reset values.
  localparam int COLS_BITS  = 11;
  localparam int ROWS_BITS  = 12;
  localparam int CFG_BITS   = 12;
  localparam int COLS_RESET = 1024;
  localparam int ROWS_RESET = 1024;

  // One sample completes at most four positions (the frame's last corner).
  localparam int MAX_RESULTS = 4;
  // Result queue depth, a power of two.
  localparam int OUT_DEPTH   = 16;

  typedef enum logic [0:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_reg_t;

  // Which results a sample produces, and the edge conditions of the column
  // and row positions that its results refer to.
  typedef struct packed {
    logic has_a;    // position one row up, one column left
    logic has_b;    // position one row up, this column (row end)
    logic has_c;    // this row, one column left (last row)
    logic has_d;    // this row, this column (last row, row end)
    logic cp_zero;  // column to the left is the first column
    logic cp_last;  // column to the left is at or past the last column
    logic c_zero;   // this column is the first column
    logic c_last;   // this column is at or past the last column
    logic rp_zero;  // row above is the first row
    logic rp_last;  // row above is at or past the last row
    logic r_zero;   // this row is the first row
    logic r_last;   // this row is at or past the last row
  } pos_flags_t;

endpackage

// ===== hw/rtl/cdg_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one signed sample per beat.
// ----------------------------------------------------------------------------
interface cdg_sample_if #(
  parameter int SAMPLE_BITS = cdg_pkg::SAMPLE_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/cdg_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one gradient result per beat.
// ----------------------------------------------------------------------------
interface cdg_result_if #(
  parameter int SAMPLE_BITS = cdg_pkg::SAMPLE_BITS_DEFAULT
);
  localparam int OUT_BITS = SAMPLE_BITS + 2;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] dx_half;
  logic signed [OUT_BITS-1:0] dy_half;
  logic                       last_in_run;
  logic                       frame_end;

  modport source (output valid, output dx_half, output dy_half, output last_in_run,
                  output frame_end, input ready);
  modport sink   (input valid, input dx_half, input dy_half, input last_in_run,
                  input frame_end, output ready);
endinterface

// ===== hw/rtl/cdg_raster_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster position control
// Holds the frame size registers and the column and row counters, and
// derives the result and edge flags for the sample at the current position.
// ----------------------------------------------------------------------------
module cdg_raster_ctl #(
  parameter int MAX_COLS = cdg_pkg::MAX_COLS_DEFAULT,
  localparam int CW      = $clog2(MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  cdg_pkg::cfg_reg_t             cfg_index,
  input  logic [cdg_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          accept,
  output logic [CW-1:0]                 col,
  output cdg_pkg::pos_flags_t           flags
);

  localparam int RB = cdg_pkg::ROWS_BITS;
  localparam int LAST_COL_RESET =
    ((cdg_pkg::COLS_RESET < MAX_COLS) ? cdg_pkg::COLS_RESET : MAX_COLS) - 1;
  localparam int LAST_ROW_RESET = cdg_pkg::ROWS_RESET - 1;

  logic [CW-1:0]                 last_col;
  logic [RB-1:0]                 row;
  logic [RB-1:0]                 last_row;
  logic [cdg_pkg::COLS_BITS-1:0] cols_val;
  logic [RB-1:0]                 rows_val;
  logic [CW-1:0]                 last_col_next;
  logic [RB-1:0]                 last_row_next;
  logic                          end_col;
  logic                          end_row;

  // The registers are stored as last index, already clamped to the legal range.
  always_comb begin
    cols_val = cfg_data[cdg_pkg::COLS_BITS-1:0];
    rows_val = cfg_data[RB-1:0];
    if (cols_val < cdg_pkg::COLS_BITS'(2)) begin
      last_col_next = CW'(1);
    end else if (32'(cols_val) > MAX_COLS) begin
      last_col_next = CW'(MAX_COLS - 1);
    end else begin
      last_col_next = CW'(cols_val - cdg_pkg::COLS_BITS'(1));
    end
    if (rows_val < RB'(2)) begin
      last_row_next = RB'(1);
    end else begin
      last_row_next = rows_val - RB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= CW'(LAST_COL_RESET);
      last_row <= RB'(LAST_ROW_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        cdg_pkg::CFG_COLUMNS: last_col <= last_col_next;
        cdg_pkg::CFG_ROWS:    last_row <= last_row_next;
      endcase
    end
  end

  assign end_col = col >= last_col;
  assign end_row = row >= last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (end_col) begin
        col <= '0;
        row <= end_row ? '0 : row + RB'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_comb begin
    flags.has_a   = (row != '0) && (col != '0);
    flags.has_b   = (row != '0) && end_col;
    flags.has_c   = (row != '0) && end_row && (col != '0);
    flags.has_d   = (row != '0) && end_row && end_col;
    flags.cp_zero = col == CW'(1);
    flags.cp_last = col > last_col;
    flags.c_zero  = col == '0;
    flags.c_last  = end_col;
    flags.rp_zero = row == RB'(1);
    flags.rp_last = row > last_row;
    flags.r_zero  = row == '0;
    flags.r_last  = end_row;
  end

endmodule

// ===== hw/rtl/cdg_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line store
// Simple dual-port synchronous RAM holding the two preceding rows, one word
// per column. Read data is registered.
// ----------------------------------------------------------------------------
module cdg_line_store #(
  parameter int DEPTH  = cdg_pkg::MAX_COLS_DEFAULT,
  parameter int WIDTH  = 2 * cdg_pkg::SAMPLE_BITS_DEFAULT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/cdg_diff_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference datapath
// Reads the line store at the sample's column, then in the following cycle
// forms up to four results from the stored rows and the recent samples,
// writes the column back and advances the neighbor registers.
// ----------------------------------------------------------------------------
module cdg_diff_core #(
  parameter int MAX_COLS    = cdg_pkg::MAX_COLS_DEFAULT,
  parameter int SAMPLE_BITS = cdg_pkg::SAMPLE_BITS_DEFAULT,
  localparam int CW         = $clog2(MAX_COLS),
  localparam int OW         = SAMPLE_BITS + 2,
  localparam int RW         = 2 * OW + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [CW-1:0]                 col,
  input  cdg_pkg::pos_flags_t           flags,
  output logic [cdg_pkg::MAX_RESULTS-1:0] push_valid,
  output logic [RW-1:0]                 push_data [cdg_pkg::MAX_RESULTS]
);

  localparam int SW = SAMPLE_BITS;
  localparam int NR = cdg_pkg::MAX_RESULTS;

  function automatic logic signed [OW-1:0] diff_half(
    input logic signed [SW-1:0] lo,
    input logic signed [SW-1:0] mid,
    input logic signed [SW-1:0] hi,
    input logic                 at_zero,
    input logic                 at_last
  );
    logic signed [OW-1:0] l;
    logic signed [OW-1:0] m;
    logic signed [OW-1:0] h;
    l = {{2{lo[SW-1]}}, lo};
    m = {{2{mid[SW-1]}}, mid};
    h = {{2{hi[SW-1]}}, hi};
    priority if (at_zero) begin
      return (h - m) <<< 1;
    end else if (at_last) begin
      return (m - l) <<< 1;
    end else begin
      return h - l;
    end
  endfunction

  logic                       s1_valid;
  logic signed [SW-1:0]       s1_sample;
  logic [CW-1:0]              s1_col;
  cdg_pkg::pos_flags_t        s1_flags;

  logic [2*SW-1:0]            rd_word;
  logic signed [SW-1:0]       p;
  logic signed [SW-1:0]       o;

  logic signed [SW-1:0]       above_left;
  logic signed [SW-1:0]       above_centre;
  logic signed [SW-1:0]       two_above_centre;
  logic signed [SW-1:0]       prior_sample;
  logic signed [SW-1:0]       second_prior_sample;

  logic signed [OW-1:0]       dx [NR];
  logic signed [OW-1:0]       dy [NR];
  logic [NR-1:0]              slot_valid;
  logic [NR-1:0]              slot_last;
  logic [NR-1:0]              slot_frame_end;

  // Word layout: upper half is the row two above, lower half the row above.
  // Back-to-back samples never share a column (a row has at least two), so the
  // write-back of one item and the read of the next never collide.
  cdg_line_store #(
    .DEPTH (MAX_COLS),
    .WIDTH (2 * SW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_word),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data ({p, s1_sample})
  );

  assign p = rd_word[SW-1:0];
  assign o = rd_word[2*SW-1:SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= sample;
      s1_col    <= col;
      s1_flags  <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above_left          <= '0;
      above_centre        <= '0;
      two_above_centre    <= '0;
      prior_sample        <= '0;
      second_prior_sample <= '0;
    end else if (s1_valid) begin
      two_above_centre    <= o;
      above_left          <= above_centre;
      above_centre        <= p;
      second_prior_sample <= prior_sample;
      prior_sample        <= s1_sample;
    end
  end

  // Results in raster order: the position up and left, the one straight up at
  // a row end, and on the last row the position to the left and this one.
  always_comb begin
    dx[0] = diff_half(above_left, above_centre, p, s1_flags.cp_zero, s1_flags.cp_last);
    dy[0] = diff_half(two_above_centre, above_centre, prior_sample,
                      s1_flags.rp_zero, s1_flags.rp_last);
    dx[1] = diff_half(above_centre, p, '0, s1_flags.c_zero, s1_flags.c_last);
    dy[1] = diff_half(o, p, s1_sample, s1_flags.rp_zero, s1_flags.rp_last);
    dx[2] = diff_half(second_prior_sample, prior_sample, s1_sample,
                      s1_flags.cp_zero, s1_flags.cp_last);
    dy[2] = diff_half(above_centre, prior_sample, '0, s1_flags.r_zero, s1_flags.r_last);
    dx[3] = diff_half(prior_sample, s1_sample, '0, s1_flags.c_zero, s1_flags.c_last);
    dy[3] = diff_half(p, s1_sample, '0, s1_flags.r_zero, s1_flags.r_last);

    slot_valid[0] = s1_valid && s1_flags.has_a;
    slot_valid[1] = s1_valid && s1_flags.has_b;
    slot_valid[2] = s1_valid && s1_flags.has_c;
    slot_valid[3] = s1_valid && s1_flags.has_d;

    slot_last[0] = slot_valid[0] && !(|slot_valid[3:1]);
    slot_last[1] = slot_valid[1] && !(|slot_valid[3:2]);
    slot_last[2] = slot_valid[2] && !slot_valid[3];
    slot_last[3] = slot_valid[3];

    slot_frame_end = {1'b1, 3'b000};

    for (int k = 0; k < NR; k++) begin
      push_data[k] = {dx[k], dy[k], slot_last[k], slot_frame_end[k]};
    end
  end

  assign push_valid = slot_valid;

endmodule

// ===== hw/rtl/cdg_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// FIFO that takes up to four results per cycle in order and hands out one
// per beat. Reports whether another sample's worth of results will fit.
// ----------------------------------------------------------------------------
module cdg_out_fifo #(
  parameter int WIDTH = 2 * (cdg_pkg::SAMPLE_BITS_DEFAULT + 2) + 2,
  parameter int DEPTH = cdg_pkg::OUT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [cdg_pkg::MAX_RESULTS-1:0] push_valid,
  input  logic [WIDTH-1:0]                push_data [cdg_pkg::MAX_RESULTS],
  output logic                            room,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [WIDTH-1:0]                out_data
);

  localparam int NR   = cdg_pkg::MAX_RESULTS;
  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int NW   = $clog2(NR + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic [PW-1:0]    offset [NR];
  logic [NW-1:0]    npush;
  logic             pop;

  // Valid results are packed together; each lands after the earlier ones.
  always_comb begin
    npush = '0;
    for (int k = 0; k < NR; k++) begin
      offset[k] = PW'(npush);
      npush     = npush + NW'(push_valid[k]);
    end
  end

  assign out_valid = count != '0;
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  // A new sample is taken only if its results cannot overflow the queue,
  // counting those of the sample still in the datapath.
  assign room = ({1'b0, count} + (CNTW + 1)'(npush)) <= (CNTW + 1)'(DEPTH - NR);

  always_ff @(posedge clk) begin
    for (int k = 0; k < NR; k++) begin
      if (push_valid[k]) begin
        slots[wr_ptr + offset[k]] <= push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(npush);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CNTW'(npush) - CNTW'(pop);
    end
  end

endmodule

// ===== hw/rtl/central_difference_gradient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Central difference gradient
// Horizontal and vertical derivatives, in half units, of a raster stream.
// ----------------------------------------------------------------------------
// Samples enter on the samples channel in raster order, one per beat. Each
// result beat on the results channel carries dx_half and dy_half for one
// position, last_in_run on the final result caused by a sample and frame_end
// on the frame's final position. A position is reported when the sample one
// row below and one column right arrives; the last row is reported as it
// arrives, so a row end gives two results, each last-row sample after the
// first two, and the frame's final sample four. First-row samples give none.
// With the queue empty, a result passes the stage registers and is written
// into the queue before it shows on the results channel. Samples are taken one
// per cycle, limited by the single line store port per sample and by the result
// port, which delivers one result per cycle through a 16-entry queue; samples
// wait while the queue cannot take another four results.
// Frame size is set through cfg_write/cfg_index/cfg_data while idle.
// Reset returns the position to the frame origin and the size to 1024 by
// 1024; the line store is not cleared, since the first row fills it before
// any read of it is used. A stalled receiver fills the queue, then the
// samples channel deasserts ready until there is room again.
// ----------------------------------------------------------------------------
module central_difference_gradient #(
  parameter int MAX_COLS    = cdg_pkg::MAX_COLS_DEFAULT,
  parameter int SAMPLE_BITS = cdg_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [0:0]                   cfg_index,
  input  logic [cdg_pkg::CFG_BITS-1:0] cfg_data,
  cdg_sample_if.sink                   samples,
  cdg_result_if.source                 results
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int OW = SAMPLE_BITS + 2;
  localparam int RW = 2 * OW + 2;
  localparam int NR = cdg_pkg::MAX_RESULTS;

  logic                  accept;
  logic [CW-1:0]         col;
  cdg_pkg::pos_flags_t   flags;
  logic [NR-1:0]         push_valid;
  logic [RW-1:0]         push_data [NR];
  logic                  room;
  logic [RW-1:0]         out_data;

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = room;

  cdg_raster_ctl #(
    .MAX_COLS (MAX_COLS)
  ) u_raster_ctl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cdg_pkg::cfg_reg_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col       (col),
    .flags     (flags)
  );

  cdg_diff_core #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_diff_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (samples.sample),
    .col        (col),
    .flags      (flags),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  cdg_out_fifo #(
    .WIDTH (RW),
    .DEPTH (cdg_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .room       (room),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_data   (out_data)
  );

  assign results.dx_half     = out_data[RW-1 -: OW];
  assign results.dy_half     = out_data[OW+1 -: OW];
  assign results.last_in_run = out_data[1];
  assign results.frame_end   = out_data[0];

endmodule

// ===== tb/tb_central_difference_gradient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Central difference gradient testbench
// Streams frames of signed samples through the gradient block under random
// sender bursts and receiver stalls, and checks every result beat against a
// local model of the line stores and edge rules. Frame sizes change between
// frames and, once the line stores hold data, in the middle of a frame too.
// ----------------------------------------------------------------------------
module tb_central_difference_gradient;

  localparam int SAMPLE_BITS = cdg_pkg::SAMPLE_BITS_DEFAULT;
  localparam int MAX_COLS    = cdg_pkg::MAX_COLS_DEFAULT;
  localparam int OUT_BITS    = SAMPLE_BITS + 2;
  localparam int CFG_BITS    = cdg_pkg::CFG_BITS;
  localparam int COLS_BITS   = cdg_pkg::COLS_BITS;
  localparam int ROWS_BITS   = cdg_pkg::ROWS_BITS;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLDOFF_LEN = 400;

  typedef struct {
    logic signed [OUT_BITS-1:0] dx;
    logic signed [OUT_BITS-1:0] dy;
    logic                       last;
    logic                       fe;
  } gradient_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [0:0]          cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  cdg_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  cdg_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

  central_difference_gradient #(
    .MAX_COLS   (MAX_COLS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (sample_ch),
    .results  (result_ch)
  );

  logic signed [SAMPLE_BITS-1:0] pending_samples[$];
  gradient_t                     expected_gradients[$];
  int                            mismatch_count;
  int                            result_count;
  int                            cycle_count;

  // Model state: line stores, sample history and raster position.
  logic signed [SAMPLE_BITS-1:0] prev_line[MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] older_line[MAX_COLS];
  int                            last_sample;
  int                            second_last_sample;
  int                            up_left;
  int                            up_centre;
  int                            two_up_centre;
  int unsigned                   row_pos;
  int unsigned                   col_pos;
  logic [COLS_BITS-1:0]          cols_setting;
  logic [ROWS_BITS-1:0]          rows_setting;

  logic holdoff_req;
  logic holdoff_done;
  int   holdoff_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned eff_cols();
    int unsigned n;
    n = cols_setting;
    if (n < 2) n = 2;
    if (n > MAX_COLS) n = MAX_COLS;
    return n;
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned n;
    n = rows_setting;
    if (n < 2) n = 2;
    return n;
  endfunction

  // Edge-aware difference in half units: forward at the start, backward at or
  // past the end, central in between.
  function automatic int half_diff(int lo, int mid, int hi, int unsigned pos,
                                   int unsigned last);
    if (pos == 0) return 2 * (hi - mid);
    if (pos >= last) return 2 * (mid - lo);
    return hi - lo;
  endfunction

  // Samples still needed to reach the end of the current frame.
  function automatic int samples_to_frame_end();
    int unsigned nc;
    int unsigned nr;
    int          row_left;
    nc = eff_cols();
    nr = eff_rows();
    row_left = (col_pos >= nc - 1) ? 1 : int'(nc - col_pos);
    if (row_pos >= nr - 1) return row_left;
    return row_left + int'((nr - 1 - row_pos) * nc);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return -16'sh8000;
      2:       return SAMPLE_BITS'($urandom_range(0, 16) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic predict_gradient(input logic signed [SAMPLE_BITS-1:0] s_in);
    gradient_t   run[cdg_pkg::MAX_RESULTS];
    int          n;
    int unsigned nc;
    int unsigned nr;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    int          s;
    int          p;
    int          o;
    bit          end_col;
    bit          end_row;
    n = 0;
    nc = eff_cols();
    nr = eff_rows();
    c = col_pos;
    r = row_pos;
    s = s_in;
    idx = (c < MAX_COLS) ? c : MAX_COLS - 1;
    p = prev_line[idx];
    o = older_line[idx];
    end_col = (c >= nc - 1);
    end_row = (r >= nr - 1);
    if (r >= 1) begin
      if (c >= 1) begin
        run[n] = '{OUT_BITS'(half_diff(up_left, up_centre, p, c - 1, nc - 1)),
                   OUT_BITS'(half_diff(two_up_centre, up_centre, last_sample, r - 1, nr - 1)),
                   1'b0, 1'b0};
        n++;
      end
      if (end_col) begin
        run[n] = '{OUT_BITS'(half_diff(up_centre, p, 0, c, nc - 1)),
                   OUT_BITS'(half_diff(o, p, s, r - 1, nr - 1)), 1'b0, 1'b0};
        n++;
      end
      if (end_row) begin
        if (c >= 1) begin
          run[n] = '{OUT_BITS'(half_diff(second_last_sample, last_sample, s, c - 1, nc - 1)),
                     OUT_BITS'(half_diff(up_centre, last_sample, 0, r, nr - 1)),
                     1'b0, 1'b0};
          n++;
        end
        if (end_col) begin
          run[n] = '{OUT_BITS'(half_diff(last_sample, s, 0, c, nc - 1)),
                     OUT_BITS'(half_diff(p, s, 0, r, nr - 1)), 1'b0, 1'b1};
          n++;
        end
      end
    end
    if (n > 0) run[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_gradients.push_back(run[k]);

    older_line[idx] = SAMPLE_BITS'(p);
    prev_line[idx] = s_in;
    two_up_centre = o;
    up_left = up_centre;
    up_centre = p;
    second_last_sample = last_sample;
    last_sample = s;
    if (end_col) begin
      col_pos = 0;
      row_pos = end_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Sample driver: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.sample <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        predict_gradient(sample_ch.sample);
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left != 0 || pending_samples.size() == 0) begin
          if (gap_left != 0) gap_left--;
          sample_ch.valid <= 1'b0;
        end else begin
          sample_ch.valid <= 1'b1;
          sample_ch.sample <= pending_samples.pop_front();
          burst_left--;
        end
      end
    end
  end

  // Result monitor; the receiver switches its stall pattern after each run of
  // random length.
  int stall_mode;
  int mode_left;
  bit ready_bit;

  always @(posedge clk) begin
    gradient_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      mode_left = 0;
      stall_mode = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        result_count++;
        if (expected_gradients.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d with nothing expected: dx=%0d dy=%0d last=%0b end=%0b",
                     result_count, result_ch.dx_half, result_ch.dy_half,
                     result_ch.last_in_run, result_ch.frame_end);
        end else begin
          want = expected_gradients.pop_front();
          if (result_ch.dx_half !== want.dx || result_ch.dy_half !== want.dy ||
              result_ch.last_in_run !== want.last || result_ch.frame_end !== want.fe) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected dx=%0d dy=%0d last=%0b end=%0b, got dx=%0d dy=%0d last=%0b end=%0b",
                       result_count, want.dx, want.dy, want.last, want.fe,
                       result_ch.dx_half, result_ch.dy_half,
                       result_ch.last_in_run, result_ch.frame_end);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        0:       ready_bit = 1'b1;
        1:       ready_bit = $urandom_range(0, 1);
        2:       ready_bit = ($urandom_range(0, 3) == 0);
        default: ready_bit = mode_left[0];
      endcase
      result_ch.ready <= ready_bit && (holdoff_left == 0);
    end
  end

  // One long receiver hold-off, so that the result queue fills and the
  // sample channel has to back off.
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_req && !holdoff_done) begin
      holdoff_left <= HOLDOFF_LEN;
      holdoff_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input cdg_pkg::cfg_reg_t which,
                           input logic [CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    if (which == cdg_pkg::CFG_COLUMNS) cols_setting = value[COLS_BITS-1:0];
    else rows_setting = value[ROWS_BITS-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_samples(input int n);
    repeat (n) pending_samples.push_back(random_sample());
  endtask

  // Waits until every sample has gone in and every result has come out, then
  // waits out a sample that is still in flight without a result. The check
  // runs a little after each edge, once the driver has updated.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_samples.size() != 0 || sample_ch.valid ||
               expected_gradients.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic signed [SAMPLE_BITS-1:0] square[9];
    int                            n;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready = 1'b0;
    holdoff_req = 1'b0;
    mismatch_count = 0;
    result_count = 0;
    cycle_count = 0;
    for (int k = 0; k < MAX_COLS; k++) begin
      prev_line[k] = '0;
      older_line[k] = '0;
    end
    last_sample = 0;
    second_last_sample = 0;
    up_left = 0;
    up_centre = 0;
    two_up_centre = 0;
    row_pos = 0;
    col_pos = 0;
    cols_setting = COLS_BITS'(cdg_pkg::COLS_RESET);
    rows_setting = ROWS_BITS'(cdg_pkg::ROWS_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame, sizes below the minimum; the last sample gives all four
    // corner results.
    write_reg(cdg_pkg::CFG_COLUMNS, 12'd0);
    write_reg(cdg_pkg::CFG_ROWS, 12'd1);
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(-16'sh8000);
    pending_samples.push_back(-16'sh8000);
    pending_samples.push_back(16'sh7FFF);
    wait_idle();

    // Three by three, so the centre position takes both central differences.
    write_reg(cdg_pkg::CFG_COLUMNS, 12'd3);
    write_reg(cdg_pkg::CFG_ROWS, 12'd3);
    square = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh0000,
               -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF};
    foreach (square[k]) pending_samples.push_back(square[k]);
    wait_idle();

    // Sizes shrink mid-frame: the column index passes the new last column,
    // then the row index passes the new last row.
    write_reg(cdg_pkg::CFG_COLUMNS, 12'd4);
    write_reg(cdg_pkg::CFG_ROWS, 12'd4);
    queue_samples(6);
    wait_idle();
    write_reg(cdg_pkg::CFG_COLUMNS, 12'd2);
    queue_samples(1);
    wait_idle();
    write_reg(cdg_pkg::CFG_ROWS, 12'd2);
    queue_samples(2);
    wait_idle();

    // Small whole frames of random size and content.
    repeat (4) begin
      write_reg(cdg_pkg::CFG_COLUMNS, CFG_BITS'($urandom_range(0, 9)));
      write_reg(cdg_pkg::CFG_ROWS, CFG_BITS'($urandom_range(0, 4)));
      queue_samples(samples_to_frame_end());
      wait_idle();
    end

    // Sixteen columns once the value is masked to 11 bits, rows clamped to two.
    // This fills both line stores for every column that later frames reach.
    write_reg(cdg_pkg::CFG_COLUMNS, 12'h810);
    write_reg(cdg_pkg::CFG_ROWS, 12'h000);
    queue_samples(samples_to_frame_end());
    wait_idle();

    // Start of a tall frame, with the long receiver hold-off while it streams.
    write_reg(cdg_pkg::CFG_COLUMNS, 12'h802);
    write_reg(cdg_pkg::CFG_ROWS, 12'hFFF);
    queue_samples(30);
    holdoff_req <= 1'b1;
    wait_idle();

    // Random size changes in the middle of frames. Columns stay within the
    // line store entries written above; rows may take any value.
    repeat (2) begin
      write_reg(cdg_pkg::CFG_COLUMNS, CFG_BITS'($urandom_range(2, 12)));
      write_reg(cdg_pkg::CFG_ROWS, CFG_BITS'($urandom_range(2, 4)));
      n = samples_to_frame_end();
      queue_samples($urandom_range(1, n - 1));
      wait_idle();
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 1)) begin
          write_reg(cdg_pkg::CFG_ROWS,
                    ($urandom_range(0, 3) == 0) ? CFG_BITS'($urandom_range(0, 4095))
                                                : CFG_BITS'($urandom_range(0, 14)));
        end else begin
          write_reg(cdg_pkg::CFG_COLUMNS, CFG_BITS'($urandom_range(0, 14)));
        end
        queue_samples($urandom_range(1, 12));
        wait_idle();
      end
      write_reg(cdg_pkg::CFG_ROWS, CFG_BITS'($urandom_range(0, 3)));
      write_reg(cdg_pkg::CFG_COLUMNS, CFG_BITS'($urandom_range(0, 8)));
      queue_samples(samples_to_frame_end());
      wait_idle();
    end

    if (mismatch_count == 0 && expected_gradients.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
